// ----- rtl/i2cm_pkg.sv -----
package i2cm_pkg;

  localparam int unsigned DelayWidth = 10;
  localparam logic [DelayWidth-1:0] DelayReset = 10'd10;

  // Command codes carried on the request side.
  typedef enum logic [1:0] {
    ACT_TICK       = 2'd0,
    ACT_WRITE_REG  = 2'd1,
    ACT_READ_BYTE  = 2'd2,
    ACT_READ_WORD  = 2'd3
  } action_t;

  // Which byte of the transfer is in flight.
  typedef enum logic [1:0] {
    PH_DEVICE   = 2'd0,
    PH_REGISTER = 2'd1,
    PH_DATA     = 2'd2,
    PH_READ     = 2'd3
  } phase_t;

  // Bus sequencer steps, one-hot.
  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_ST1  = 16'h0002,
    ST_ST2  = 16'h0004,
    ST_TB1  = 16'h0008,
    ST_TB2  = 16'h0010,
    ST_TB3  = 16'h0020,
    ST_TA1  = 16'h0040,
    ST_TA2  = 16'h0080,
    ST_TA3  = 16'h0100,
    ST_TA4  = 16'h0200,
    ST_RB1  = 16'h0400,
    ST_RB2  = 16'h0800,
    ST_AK1  = 16'h1000,
    ST_AK2  = 16'h2000,
    ST_SP1  = 16'h4000,
    ST_SP2  = 16'h8000
  } step_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  // Packed so that scl_level lands in bit 0, matching the result tdata.
  typedef struct packed {
    logic        nack_seen;
    logic [15:0] read_value;
    logic        done_res;
    logic        busy_res;
    logic        sda_drive_enable;
    logic        sda_level;
    logic        scl_level;
  } result_t;

endpackage

// ----- rtl/i2cm_seq.sv -----
module i2cm_seq
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  item_t                 item,
  input  logic [DelayWidth-1:0] half_period,
  output result_t               result
);

  step_t                 step, step_next;
  logic [DelayWidth-1:0] delay_count, delay_count_next;
  logic [2:0]            bit_count, bit_count_next;
  logic [7:0]            shift_byte, shift_byte_next;
  action_t               cmd, cmd_next;
  logic [7:0]            dev, dev_next;
  logic [7:0]            reg_addr, reg_addr_next;
  logic [7:0]            data, data_next;
  logic                  second_read, second_read_next;
  logic [15:0]           result_word, result_word_next;
  logic                  nack, nack_next;
  phase_t                phase, phase_next;
  logic                  scl, scl_next;
  logic                  sda, sda_next;
  logic                  drv, drv_next;

  always_comb begin
    logic [DelayWidth-1:0] len;
    logic [DelayWidth-1:0] cnt;
    logic                  do_start;
    logic                  do_stop;
    logic                  do_send;
    logic [7:0]            send_val;
    logic                  done;

    step_next        = step;
    delay_count_next = delay_count;
    bit_count_next   = bit_count;
    shift_byte_next  = shift_byte;
    cmd_next         = cmd;
    dev_next         = dev;
    reg_addr_next    = reg_addr;
    data_next        = data;
    second_read_next = second_read;
    result_word_next = result_word;
    nack_next        = nack;
    phase_next       = phase;
    scl_next         = scl;
    sda_next         = sda;
    drv_next         = drv;
    do_start         = 1'b0;
    do_stop          = 1'b0;
    do_send          = 1'b0;
    send_val         = 8'd0;
    done             = 1'b0;
    len              = (half_period == '0) ? DelayWidth'(1) : half_period;
    cnt              = delay_count + DelayWidth'(1);

    if (step == ST_IDLE) begin
      if (item.action != ACT_TICK) begin
        cmd_next         = item.action;
        dev_next         = item.device_address;
        reg_addr_next    = item.register_address;
        data_next        = item.write_data;
        nack_next        = 1'b0;
        second_read_next = 1'b0;
        phase_next       = PH_DEVICE;
        delay_count_next = '0;
        do_start         = 1'b1;
      end
    end else if (cnt >= len) begin
      delay_count_next = '0;
      case (step)
        ST_ST1: begin
          sda_next  = 1'b0;
          step_next = ST_ST2;
        end
        ST_ST2: begin
          scl_next = 1'b0;
          do_send  = 1'b1;
          send_val = (phase == PH_READ) ? 8'(dev + 8'd1) : dev;
        end
        ST_TB1: begin
          scl_next  = 1'b1;
          step_next = ST_TB2;
        end
        ST_TB2: begin
          scl_next  = 1'b0;
          step_next = ST_TB3;
        end
        ST_TB3: begin
          if (bit_count == 3'd7) begin
            step_next = ST_TA1;
          end else begin
            bit_count_next  = bit_count + 3'd1;
            shift_byte_next = {shift_byte[6:0], 1'b0};
            sda_next        = shift_byte[6];
            step_next       = ST_TB1;
          end
        end
        ST_TA1: begin
          sda_next  = 1'b1;
          step_next = ST_TA2;
        end
        ST_TA2: begin
          scl_next  = 1'b1;
          step_next = ST_TA3;
        end
        ST_TA3: begin
          drv_next = 1'b0;
          if (item.sda_in) begin
            nack_next = 1'b1;
          end
          scl_next  = 1'b0;
          step_next = ST_TA4;
        end
        ST_TA4: begin
          case (phase)
            PH_DEVICE: begin
              phase_next = PH_REGISTER;
              do_send    = 1'b1;
              send_val   = reg_addr;
            end
            PH_REGISTER: begin
              if (cmd == ACT_WRITE_REG) begin
                phase_next = PH_DATA;
                do_send    = 1'b1;
                send_val   = data;
              end else begin
                phase_next = PH_READ;
                do_start   = 1'b1;
              end
            end
            PH_DATA: begin
              do_stop = 1'b1;
            end
            default: begin
              // Turn the bus around for the eight data bits.
              scl_next        = 1'b1;
              sda_next        = 1'b1;
              drv_next        = 1'b0;
              bit_count_next  = 3'd0;
              shift_byte_next = 8'd0;
              step_next       = ST_RB1;
            end
          endcase
        end
        ST_RB1: begin
          shift_byte_next = {shift_byte[6:0], item.sda_in};
          scl_next        = 1'b0;
          step_next       = ST_RB2;
        end
        ST_RB2: begin
          if (bit_count == 3'd7) begin
            if (cmd == ACT_READ_WORD && !second_read) begin
              result_word_next = {shift_byte, 8'd0};
            end else if (cmd == ACT_READ_WORD) begin
              result_word_next = {result_word[15:8], shift_byte};
            end else begin
              result_word_next = {8'd0, shift_byte};
            end
            scl_next  = 1'b1;
            sda_next  = 1'b1;
            drv_next  = 1'b1;
            step_next = ST_AK1;
          end else begin
            bit_count_next = bit_count + 3'd1;
            scl_next       = 1'b1;
            step_next      = ST_RB1;
          end
        end
        ST_AK1: begin
          scl_next  = 1'b0;
          step_next = ST_AK2;
        end
        ST_AK2: begin
          do_stop = 1'b1;
        end
        ST_SP1: begin
          sda_next  = 1'b1;
          step_next = ST_SP2;
        end
        ST_SP2: begin
          if (cmd == ACT_READ_WORD && !second_read) begin
            second_read_next = 1'b1;
            reg_addr_next    = reg_addr + 8'd1;
            phase_next       = PH_DEVICE;
            do_start         = 1'b1;
          end else begin
            step_next = ST_IDLE;
            done      = 1'b1;
          end
        end
        default: begin
          step_next = ST_IDLE;
        end
      endcase
    end else begin
      delay_count_next = cnt;
    end

    if (do_start) begin
      scl_next  = 1'b1;
      sda_next  = 1'b1;
      drv_next  = 1'b1;
      step_next = ST_ST1;
    end
    if (do_stop) begin
      scl_next  = 1'b1;
      sda_next  = 1'b0;
      drv_next  = 1'b1;
      step_next = ST_SP1;
    end
    if (do_send) begin
      shift_byte_next = send_val;
      bit_count_next  = 3'd0;
      drv_next        = 1'b1;
      sda_next        = send_val[7];
      step_next       = ST_TB1;
    end

    result.scl_level        = scl_next;
    result.sda_level        = sda_next;
    result.sda_drive_enable = drv_next;
    result.busy_res         = (step_next != ST_IDLE);
    result.done_res         = done;
    result.read_value       = result_word_next;
    result.nack_seen        = nack_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= ST_IDLE;
      delay_count <= '0;
      bit_count   <= 3'd0;
      shift_byte  <= 8'd0;
      cmd         <= ACT_TICK;
      dev         <= 8'd0;
      reg_addr    <= 8'd0;
      data        <= 8'd0;
      second_read <= 1'b0;
      result_word <= 16'd0;
      nack        <= 1'b0;
      phase       <= PH_DEVICE;
      scl         <= 1'b1;
      sda         <= 1'b1;
      drv         <= 1'b0;
    end else if (en) begin
      step        <= step_next;
      delay_count <= delay_count_next;
      bit_count   <= bit_count_next;
      shift_byte  <= shift_byte_next;
      cmd         <= cmd_next;
      dev         <= dev_next;
      reg_addr    <= reg_addr_next;
      data        <= data_next;
      second_read <= second_read_next;
      result_word <= result_word_next;
      nack        <= nack_next;
      phase       <= phase_next;
      scl         <= scl_next;
      sda         <= sda_next;
      drv         <= drv_next;
    end
  end

endmodule

// ----- rtl/i2c_master_register_access.sv -----
// Channel   Direction  Signals                        Contents
// s_axis    request    tvalid/tready/tuser/tdata      one command or tick per request
// m_axis    result     tvalid/tready/tdata            pin levels and status per request
// cfg       write      cfg_we/cfg_wdata               half_period_ticks
//
// Every request produces exactly one result, and a new request is taken in every
// cycle unless the result side stalls: the sequencer's next state is one short step
// of logic between the input register and the result register.
// Reset is synchronous and active high; it returns the bus to SCL high with SDA
// released and loads half_period_ticks with ten.
// A stalled result holds in the result register while the input register keeps
// its request; s_axis_tready falls only when both are full.
module i2c_master_register_access
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Request side.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [1:0]            s_axis_tuser,  // [1:0] action
  input  logic [31:0]           s_axis_tdata,  // [7:0] device_address,
                                               // [15:8] register_address,
                                               // [23:16] write_data, [24] sda_in
  // Result side.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,  // [0] scl_level, [1] sda_level,
                                               // [2] sda_drive_enable,
                                               // [3] busy_res, [4] done_res,
                                               // [20:5] read_value, [21] nack_seen
  // Configuration.
  input  logic                  cfg_we,
  input  logic [DelayWidth-1:0] cfg_wdata
);

  logic [DelayWidth-1:0] half_period;
  logic                  in_valid;
  item_t                 in_item;
  logic                  advance;
  result_t               seq_result;
  logic                  out_valid;
  result_t               out_result;

  // The sequencer steps whenever a request is held and the result slot is free or is being read out.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= DelayReset;
    end else if (cfg_we) begin
      half_period <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.action           <= action_t'(s_axis_tuser);
      in_item.device_address   <= s_axis_tdata[7:0];
      in_item.register_address <= s_axis_tdata[15:8];
      in_item.write_data       <= s_axis_tdata[23:16];
      in_item.sda_in           <= s_axis_tdata[24];
    end
  end

  i2cm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .item        (in_item),
    .half_period (half_period),
    .result      (seq_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= seq_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_result};

endmodule

// ----- rtl/i2cm_checker.sv -----
module i2cm_checker
  import i2cm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [23:0]           m_axis_tdata
);

  // Reset empties both registers.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("block not empty after reset");

  // The end of a command is reported with the sequencer already idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[4]) |-> !m_axis_tdata[3])
    else $error("done reported while still busy");

  // An idle bus has SCL and SDA high.
  a_idle_bus: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[3]) |-> (m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("bus not released high while idle");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind i2c_master_register_access i2cm_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
